FILE: hw/rtl/float_to_fixed_round_trip_unit_defines.svh
// Assertion macros shared by the float-to-fixed round trip RTL.
// No dependencies; included by modules that carry assertions.
`ifndef FLOAT_TO_FIXED_ROUND_TRIP_UNIT_DEFINES_SVH
`define FLOAT_TO_FIXED_ROUND_TRIP_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define F2FRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("f2frt assertion failed");

// next-cycle implication, disabled in reset
`define F2FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("f2frt assertion failed");

`endif

FILE: hw/rtl/f2frt_pkg.sv
// Package for the float-to-fixed round trip unit: constants, register codes,
// and stage payload types. No dependencies.
package f2frt_pkg;

    localparam int MANT_BITS = 23;
    localparam int TOP_BIT   = 31;
    localparam int EXP_BIAS  = 127;

    localparam int INT_W   = 16;
    localparam int FRAC_W  = 15;
    localparam int JOIN_W  = INT_W + FRAC_W;
    localparam int LEAD_W  = 5;
    localparam int IW_REG_W = 5;
    localparam int FW_REG_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [IW_REG_W-1:0] IW_RESET = 5'd8;
    localparam logic [FW_REG_W-1:0] FW_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_WIDTH = 2'd1;

    typedef struct packed {
        logic              sign;
        logic [INT_W-1:0]  ipart;
        logic [FRAC_W-1:0] fpart;
        logic              ovf;
        logic [FW_REG_W-1:0] fw;
    } fix_t;

    typedef struct packed {
        logic              sign;
        logic [INT_W-1:0]  ipart;
        logic [FRAC_W-1:0] fpart;
        logic              ovf;
        logic [FW_REG_W-1:0] fw;
        logic [JOIN_W-1:0] joined;
        logic [LEAD_W-1:0] lead;
        logic [31:0]       fixed;
    } lead_t;

endpackage

FILE: hw/rtl/f2frt_convert.sv
// Float32 pattern to sign-magnitude fixed point, with saturation.
// Depends on f2frt_pkg.
module f2frt_convert (
    input  logic [31:0]                       float_bits,
    input  logic [f2frt_pkg::IW_REG_W-1:0]    integer_width,
    input  logic [f2frt_pkg::FW_REG_W-1:0]    fraction_width,
    output f2frt_pkg::fix_t                   fix
);

    logic [7:0]  expo;
    logic [23:0] mant;
    logic [4:0]  iw;
    logic [15:0] imask;
    logic [14:0] fmask;
    logic [7:0]  shift;
    logic [23:0] ish;
    logic [15:0] ipart_raw;
    logic [8:0]  famt;
    logic [30:0] fext;
    logic [30:0] fsh;
    logic        big;
    logic        ovf;
    logic [4:0]  ishift;

    always_comb
    begin
        expo = float_bits[30:23];
        mant = {1'b1, float_bits[22:0]};

        if (integer_width == 5'd0)
            iw = 5'd1;
        else if (integer_width > 5'd16)
            iw = 5'd16;
        else
            iw = integer_width;

        ishift = 5'd16 - iw;
        imask  = 16'hFFFF >> ishift[3:0];
        fmask  = 15'h7FFF >> (4'd15 - fraction_width);

        big   = (expo > 8'd142);
        shift = 8'd150 - expo;
        ish   = (shift > 8'd23) ? 24'd0 : (mant >> shift[4:0]);
        ipart_raw = ish[15:0];

        ovf = (expo != 8'd0) && (big || (ipart_raw > imask));

        famt = {1'b0, shift} + 9'd7 - {5'd0, fraction_width};
        fext = {mant, 7'd0};
        fsh  = (famt > 9'd30) ? 31'd0 : (fext >> famt[4:0]);

        fix.sign = float_bits[31];
        fix.fw   = fraction_width;
        fix.ovf  = ovf;
        if (expo == 8'd0)
        begin
            fix.ipart = '0;
            fix.fpart = '0;
        end
        else if (ovf)
        begin
            fix.ipart = imask;
            fix.fpart = fmask;
        end
        else
        begin
            fix.ipart = ipart_raw;
            fix.fpart = fsh[14:0] & fmask;
        end
    end

endmodule

FILE: hw/rtl/float_to_fixed_round_trip_unit.sv
// Top level of the float-to-fixed round trip unit: config registers and a
// three-stage pipeline. Depends on f2frt_pkg, f2frt_convert and the defines header.
//
//  channel  | direction | handshake              | payload
//  request  | in        | req_valid / req_ready  | float_bits
//  result   | out       | res_valid / res_ready  | sign_bit .. float_back
//  config   | in        | wr_en (no wait)        | wr_index, wr_data
//
// One request per cycle sustained while res_ready is high.
// Stage 1 converts to fixed, stage 2 joins and finds the leading one,
// stage 3 rebuilds the float. Reset empties the pipeline and loads 8.8.
// A stalled result holds every stage that is full; bubbles are squeezed out.
`include "float_to_fixed_round_trip_unit_defines.svh"

module float_to_fixed_round_trip_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [f2frt_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [f2frt_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [31:0]                         float_bits,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic                                sign_bit,
    output logic [15:0]                         integer_part,
    output logic [14:0]                         fraction_part,
    output logic signed [31:0]                  fixed_value,
    output logic                                overflow_flag,
    output logic [4:0]                          leading_bit,
    output logic                                truncated_flag,
    output logic [31:0]                         float_back
);

    logic [f2frt_pkg::IW_REG_W-1:0] iw_reg;
    logic [f2frt_pkg::FW_REG_W-1:0] fw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= f2frt_pkg::IW_RESET;
            fw_reg <= f2frt_pkg::FW_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                f2frt_pkg::CFG_INTEGER_WIDTH:  iw_reg <= wr_data;
                f2frt_pkg::CFG_FRACTION_WIDTH: fw_reg <= wr_data[f2frt_pkg::FW_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic adv1, adv2, adv3;

    always_comb
    begin
        adv3 = !v3_reg || res_ready;
        adv2 = !v2_reg || adv3;
        adv1 = !v1_reg || adv2;
        v1_next = adv1 ? req_valid : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
        v3_next = adv3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign req_ready = adv1;
    assign res_valid = v3_reg;

    // stage 1: float to fixed
    f2frt_pkg::fix_t fix_next, s1_reg;

    f2frt_convert u_convert (
        .float_bits     (float_bits),
        .integer_width  (iw_reg),
        .fraction_width (fw_reg),
        .fix            (fix_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= fix_next;
    end

    // stage 2: join, leading one, two's complement
    f2frt_pkg::lead_t s2_next, s2_reg;
    logic [f2frt_pkg::JOIN_W-1:0] joined;

    always_comb
    begin
        joined = ({15'd0, s1_reg.ipart} << s1_reg.fw) | {16'd0, s1_reg.fpart};
        s2_next.sign   = s1_reg.sign;
        s2_next.ipart  = s1_reg.ipart;
        s2_next.fpart  = s1_reg.fpart;
        s2_next.ovf    = s1_reg.ovf;
        s2_next.fw     = s1_reg.fw;
        s2_next.joined = joined;
        s2_next.lead   = '0;
        for (int i = 1; i < f2frt_pkg::JOIN_W; i++)
        begin
            if (joined[i])
                s2_next.lead = f2frt_pkg::LEAD_W'(i);
        end
        s2_next.fixed = s1_reg.sign ? (32'd0 - {1'b0, joined}) : {1'b0, joined};
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
            s2_reg <= s2_next;
    end

    // stage 3: rebuild float
    logic [7:0]  bexp;
    logic [30:0] lsh;
    logic [30:0] rsh;
    logic [22:0] bman;
    logic [4:0]  lamt;
    logic [4:0]  ramt;

    always_comb
    begin
        bexp = (s2_reg.joined == '0) ? 8'd0
             : (8'(f2frt_pkg::EXP_BIAS) + {3'd0, s2_reg.lead} - {4'd0, s2_reg.fw});
        lamt = 5'(f2frt_pkg::MANT_BITS) - s2_reg.lead;
        ramt = s2_reg.lead - 5'(f2frt_pkg::MANT_BITS);
        lsh  = s2_reg.joined << lamt;
        rsh  = s2_reg.joined >> ramt;
        bman = (s2_reg.lead <= 5'(f2frt_pkg::MANT_BITS)) ? lsh[22:0] : rsh[22:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            sign_bit       <= s2_reg.sign;
            integer_part   <= s2_reg.ipart;
            fraction_part  <= s2_reg.fpart;
            fixed_value    <= s2_reg.fixed;
            overflow_flag  <= s2_reg.ovf;
            leading_bit    <= s2_reg.lead;
            truncated_flag <= (s2_reg.lead > 5'(f2frt_pkg::MANT_BITS));
            float_back     <= {s2_reg.sign, bexp, bman};
        end
    end

    `F2FRT_ASSERT_NOW(a_pos_fixed, clk, rst_n, res_valid && !sign_bit, !fixed_value[31])
    `F2FRT_ASSERT_NOW(a_zero_back, clk, rst_n, res_valid && (fixed_value == 32'sd0), float_back[30:0] == 31'd0)
    `F2FRT_ASSERT_NOW(a_ovf_int, clk, rst_n, res_valid && overflow_flag, integer_part != 16'd0)
    `F2FRT_ASSERT_NEXT(a_s1_fill, clk, rst_n, req_valid && req_ready, v1_reg)
    `F2FRT_ASSERT_NEXT(a_s1_hold, clk, rst_n, v1_reg && !adv2, v1_reg)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for float_to_fixed_round_trip_unit: float32 requests
// checked field by field against a built-in fixed-point round trip predictor.
// Depends on f2frt_pkg and the RTL of the unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import f2frt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 175;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        bit        sign;
        bit [15:0] ipart;
        bit [14:0] fpart;
        bit [31:0] fixed;
        bit        ovf;
        bit [4:0]  lead;
        bit        trunc;
        bit [31:0] back;
    } conv_result_t;

    class conversion_scoreboard;
        bit [IW_REG_W-1:0] int_width_reg;
        bit [FW_REG_W-1:0] frac_width_reg;
        conv_result_t      expected_q[$];
        int                errors;

        function new();
            int_width_reg  = IW_RESET;
            frac_width_reg = FW_RESET;
            errors         = 0;
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_INTEGER_WIDTH)
                int_width_reg = data[IW_REG_W-1:0];
            else if (idx == CFG_FRACTION_WIDTH)
                frac_width_reg = data[FW_REG_W-1:0];
        endfunction

        function conv_result_t convert(bit [31:0] b);
            conv_result_t r;
            bit [7:0]  expo;
            bit [31:0] mant, imask, fmask, ipart, fpart, joined, bexp, bman;
            bit [63:0] fr;
            bit        ovf;
            int        shift, sf, iw, fw, lead;
            expo  = b[30:23];
            mant  = {9'd0, 1'b1, b[22:0]};
            iw    = (int_width_reg == 0) ? 1 : ((int_width_reg > 16) ? 16 : int_width_reg);
            fw    = frac_width_reg;
            imask = (32'd1 << iw) - 1;
            fmask = (32'd1 << fw) - 1;
            ipart = 0;
            fpart = 0;
            ovf   = 0;
            if (expo != 0)
            begin
                shift = EXP_BIAS + MANT_BITS - int'(expo);
                if (expo == 8'hFF || shift < 8)
                    ovf = 1;
                else
                begin
                    ipart = (shift > TOP_BIT) ? 32'd0 : (mant >> shift);
                    if (ipart > imask)
                        ovf = 1;
                end
                if (ovf)
                begin
                    ipart = imask;
                    fpart = fmask;
                end
                else
                begin
                    sf = shift - fw;
                    if (sf > TOP_BIT)
                        fr = 0;
                    else if (sf >= 0)
                        fr = 64'(mant >> sf);
                    else
                        fr = 64'(mant) << (-sf);
                    fpart = fr[31:0] & fmask;
                end
            end
            joined = (ipart << fw) | fpart;
            lead = TOP_BIT;
            while (lead > 0 && !joined[lead])
                lead--;
            bexp = (joined == 0) ? 32'd0 : ((EXP_BIAS + lead - fw) & 32'hFF);
            if (lead <= MANT_BITS)
                bman = joined << (MANT_BITS - lead);
            else
                bman = joined >> (lead - MANT_BITS);
            r.sign  = b[31];
            r.ipart = ipart[15:0];
            r.fpart = fpart[14:0];
            r.fixed = b[31] ? (32'd0 - joined) : joined;
            r.ovf   = ovf;
            r.lead  = lead[4:0];
            r.trunc = (lead > MANT_BITS);
            r.back  = {b[31], bexp[7:0], bman[22:0]};
            return r;
        endfunction

        function void note_request(bit [31:0] b);
            expected_q.push_back(convert(b));
        endfunction

        function void compare(string name, bit [31:0] exp_v, bit [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(conv_result_t got);
            conv_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare("sign_bit", 32'(want.sign), 32'(got.sign));
            compare("integer_part", 32'(want.ipart), 32'(got.ipart));
            compare("fraction_part", 32'(want.fpart), 32'(got.fpart));
            compare("fixed_value", want.fixed, got.fixed);
            compare("overflow_flag", 32'(want.ovf), 32'(got.ovf));
            compare("leading_bit", 32'(want.lead), 32'(got.lead));
            compare("truncated_flag", 32'(want.trunc), 32'(got.trunc));
            compare("float_back", want.back, got.back);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [31:0]           float_bits = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic                  sign_bit;
    logic [15:0]           integer_part;
    logic [14:0]           fraction_part;
    logic signed [31:0]    fixed_value;
    logic                  overflow_flag;
    logic [4:0]            leading_bit;
    logic                  truncated_flag;
    logic [31:0]           float_back;

    bit                    steady = 1'b0;
    int                    cycle_count = 0;
    conv_result_t          got_result;
    conversion_scoreboard  sb = new();

    float_to_fixed_round_trip_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .float_bits     (float_bits),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .sign_bit       (sign_bit),
        .integer_part   (integer_part),
        .fraction_part  (fraction_part),
        .fixed_value    (fixed_value),
        .overflow_flag  (overflow_flag),
        .leading_bit    (leading_bit),
        .truncated_flag (truncated_flag),
        .float_back     (float_back)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            res_ready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            got_result = {sign_bit, integer_part, fraction_part, fixed_value,
                          overflow_flag, leading_bit, truncated_flag, float_back};
            sb.check_result(got_result);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
        sb.apply_write(idx, data);
    endtask

    task automatic send_request(logic [31:0] bits);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 36)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid  <= 1'b1;
        float_bits <= bits;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(bits);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] random_float();
        logic [7:0] expo;
        case ($urandom_range(9))
            0, 1, 2: return $urandom();
            3:       return {1'($urandom()), 8'h00, 23'($urandom())};
            4:       return {1'($urandom()), 8'hFF, 23'($urandom())};
            default:
            begin
                expo = 8'($urandom_range(104, 146));
                return {1'($urandom()), expo, 23'($urandom())};
            end
        endcase
    endfunction

    logic [31:0] directed_q[$] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
        32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h4780_0000,
        32'h477F_FF00, 32'h437F_0000, 32'h4380_0000, 32'h3F00_0000,
        32'h3B80_0000, 32'h3B7F_FFFF, 32'h0080_0000, 32'h3380_0000,
        32'h4B00_0000, 32'h42F6_E979, 32'hC2F6_E979
    };

    initial
    begin
        logic [CFG_DATA_W-1:0] iw_val, fw_val;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i])
            send_request(directed_q[i]);
        drain();

        // writes to unused indexes must leave both registers alone
        write_reg(CFG_SPARE_2, 5'h1F);
        write_reg(CFG_SPARE_3, 5'h00);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin iw_val = 5'd1;  fw_val = 5'd0;  end
                1:       begin iw_val = 5'd16; fw_val = 5'd15; end
                2:       begin iw_val = 5'd0;  fw_val = 5'h1F; end
                3:       begin iw_val = 5'd31; fw_val = 5'd0;  end
                4:       begin iw_val = 5'd17; fw_val = 5'd5;  end
                5:       begin iw_val = 5'd8;  fw_val = 5'd8;  end
                default:
                begin
                    iw_val = 5'($urandom_range(31));
                    fw_val = 5'($urandom_range(31));
                end
            endcase
            write_reg(CFG_INTEGER_WIDTH, iw_val);
            write_reg(CFG_FRACTION_WIDTH, fw_val);
            steady = (p == 4);
            repeat (PHASE_ITEMS)
                send_request(random_float());
            drain();
        end

        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/f2frt_pkg.sv
hw/rtl/f2frt_convert.sv
hw/rtl/float_to_fixed_round_trip_unit.sv
tb/testbench.sv
